// ----- rtl/core/snei_pkg.sv -----
// Shared types and constants of the supernova energy injection cell.
package snei_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 31;

  localparam logic [31:0] ONE30 = 32'h4000_0000;

  localparam int MODE_CR      = 0;
  localparam int MODE_THERMAL = 1;
  localparam int MODE_SEP     = 2;
  localparam int MODE_COLOUR  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SN_CENTER,
    REG_RADIUS_SQ,
    REG_DENSITY_ADD,
    REG_THERMAL_ADD,
    REG_CR_ADD,
    REG_COLOUR_ADD,
    REG_MODE_FLAGS
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } cfg_t;

  typedef struct packed {
    logic [47:0] sn_center;
    logic [31:0] radius_sq;
    logic [31:0] density_add;
    logic [31:0] thermal_add;
    logic [31:0] cr_add;
    logic [31:0] colour_add;
    logic [3:0]  mode;
  } regs_t;

  typedef struct packed {
    logic [15:0]        cell_x;
    logic [15:0]        cell_y;
    logic [15:0]        cell_z;
    logic [31:0]        density;
    logic [31:0]        internal_energy;
    logic [31:0]        total_energy;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        cr_energy;
    logic [31:0]        colour;
  } cell_t;

  typedef struct packed {
    logic               inside_res;
    logic [31:0]        new_density;
    logic [31:0]        new_internal_energy;
    logic [31:0]        new_total_energy;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic [31:0]        new_cr_energy;
    logic [31:0]        new_colour;
  } res_t;

  typedef struct packed {
    logic        hit;
    logic        blend;
    logic        sep;
    logic        zero;
    logic [31:0] dens;
    logic [31:0] ge;
    logic [31:0] te;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] vel_z;
    logic [31:0] cr;
    logic [31:0] col;
  } pay_t;

endpackage

// ----- rtl/core/snei_stream_if.sv -----
// Valid/ready stream interface used for every channel of the block.
interface snei_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/snei_front.sv -----
// Front stages: distance test, density update, energy product and numerators.
module snei_front #(
  parameter int COORD_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_v,
  input  snei_pkg::cell_t   cell_data,
  input  snei_pkg::regs_t   regs,
  output logic              out_v,
  output logic [64:0]       num_a,
  output logic [64:0]       num_b,
  output logic [31:0]       den,
  output snei_pkg::pay_t    pay
);

  localparam int W  = COORD_BITS;
  localparam int RW = (2 * W + 2 > 33) ? 2 * W + 2 : 33;

  function automatic logic [W-1:0] axis_dist(input logic [W-1:0] c, input logic [W-1:0] p,
                                             input logic wrap);
    logic [W-1:0] d;
    logic [W:0]   alt;
    d   = (c >= p) ? c - p : p - c;
    alt = {1'b1, W'(0)} - {1'b0, d};
    if (wrap && (alt < {1'b0, d})) d = alt[W-1:0];
    return d;
  endfunction

  logic [47+W:0] ctr_ext;
  logic [32:0]   dsum;

  logic            s1_v;
  logic [W-1:0]    dx, dy, dz;
  logic [31:0]     s1_newd;
  snei_pkg::cell_t s1_cell;

  logic            s2_v;
  logic [2*W-1:0]  sqx, sqy, sqz;
  logic [63:0]     prod;
  logic [31:0]     s2_newd;
  snei_pkg::cell_t s2_cell;

  logic [RW-1:0]   r2;
  logic            hit;
  logic [32:0]     csum;
  logic [31:0]     spec;

  assign ctr_ext = {W'(0), regs.sn_center};
  assign dsum    = {1'b0, cell_data.density} + {1'b0, regs.density_add};
  assign spec    = regs.mode[snei_pkg::MODE_SEP] ? s1_cell.internal_energy
                                                 : s1_cell.total_energy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      s1_v  <= in_v;
      s2_v  <= s1_v;
      out_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx      <= axis_dist(W'(cell_data.cell_x), ctr_ext[0 +: W], 1'b1);
      dy      <= axis_dist(W'(cell_data.cell_y), ctr_ext[16 +: W], 1'b1);
      dz      <= axis_dist(W'(cell_data.cell_z), ctr_ext[32 +: W], 1'b0);
      s1_newd <= dsum[32] ? '1 : dsum[31:0];
      s1_cell <= cell_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx     <= dx * dx;
      sqy     <= dy * dy;
      sqz     <= dz * dz;
      prod    <= 64'(s1_cell.density) * 64'(spec);
      s2_newd <= s1_newd;
      s2_cell <= s1_cell;
    end
  end

  always_comb begin
    r2   = RW'(sqx) + RW'(sqy) + RW'(sqz);
    hit  = r2 <= RW'(regs.radius_sq);
    csum = {1'b0, s2_cell.colour} + {1'b0, regs.colour_add};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_a     <= 65'(prod) + 65'({regs.thermal_add, 16'h0000});
      num_b     <= 65'({s2_cell.density, 30'h0});
      den       <= s2_newd;
      pay.hit   <= hit;
      pay.blend <= hit && regs.mode[snei_pkg::MODE_THERMAL];
      pay.sep   <= regs.mode[snei_pkg::MODE_SEP];
      pay.zero  <= s2_newd == 32'h0;
      pay.dens  <= hit ? s2_newd : s2_cell.density;
      pay.ge    <= s2_cell.internal_energy;
      pay.te    <= s2_cell.total_energy;
      pay.vel_x <= s2_cell.vel_x;
      pay.vel_y <= s2_cell.vel_y;
      pay.vel_z <= s2_cell.vel_z;
      pay.cr    <= (hit && regs.mode[snei_pkg::MODE_CR]) ? regs.cr_add
                                                         : s2_cell.cr_energy;
      pay.col   <= (hit && regs.mode[snei_pkg::MODE_COLOUR])
                   ? (csum[32] ? '1 : csum[31:0]) : s2_cell.colour;
    end
  end

endmodule

// ----- rtl/core/snei_div.sv -----
// Pipelined restoring divider: two numerators over one shared denominator.
module snei_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  logic [64:0]    num_a,
  input  logic [64:0]    num_b,
  input  logic [31:0]    den,
  input  snei_pkg::pay_t in_pay,
  output logic           out_v,
  output logic [31:0]    quot_a,
  output logic [31:0]    quot_b,
  output snei_pkg::pay_t out_pay
);

  localparam int N = snei_pkg::DIV_STEPS;

  typedef struct packed {
    logic [31:0]    rem_a;
    logic [31:0]    rem_b;
    logic [31:0]    lo_a;
    logic [31:0]    lo_b;
    logic [31:0]    q_a;
    logic [31:0]    q_b;
    logic [31:0]    den;
    logic           sat;
    snei_pkg::pay_t pay;
  } div_step_t;

  function automatic div_step_t div_step(input div_step_t s);
    div_step_t  n;
    logic [32:0] sh_a, sh_b;
    logic        ge_a, ge_b;
    n       = s;
    sh_a    = {s.rem_a, s.lo_a[31]};
    sh_b    = {s.rem_b, s.lo_b[31]};
    ge_a    = sh_a >= {1'b0, s.den};
    ge_b    = sh_b >= {1'b0, s.den};
    n.rem_a = ge_a ? 32'(sh_a - {1'b0, s.den}) : sh_a[31:0];
    n.rem_b = ge_b ? 32'(sh_b - {1'b0, s.den}) : sh_b[31:0];
    n.lo_a  = {s.lo_a[30:0], 1'b0};
    n.lo_b  = {s.lo_b[30:0], 1'b0};
    n.q_a   = {s.q_a[30:0], ge_a};
    n.q_b   = {s.q_b[30:0], ge_b};
    return n;
  endfunction

  div_step_t st  [0:N];
  logic      vld [0:N];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].rem_a <= num_a[63:32];
      st[0].rem_b <= num_b[63:32];
      st[0].lo_a  <= num_a[31:0];
      st[0].lo_b  <= num_b[31:0];
      st[0].q_a   <= '0;
      st[0].q_b   <= '0;
      st[0].den   <= den;
      st[0].sat   <= num_a[64:32] >= {1'b0, den};
      st[0].pay   <= in_pay;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else if (en) vld[k] <= vld[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) st[k] <= div_step(st[k-1]);
    end
  end

  assign out_v   = vld[N];
  assign quot_a  = st[N].sat ? '1 : st[N].q_a;
  assign quot_b  = st[N].q_b;
  assign out_pay = st[N].pay;

endmodule

// ----- rtl/core/snei_sqrt.sv -----
// Energy blend selection and pipelined square root of the density ratio.
module snei_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  logic [31:0]    quot_a,
  input  logic [31:0]    quot_b,
  input  snei_pkg::pay_t in_pay,
  output logic           out_v,
  output logic [30:0]    root,
  output snei_pkg::pay_t out_pay
);

  localparam int N = snei_pkg::SQRT_STEPS;

  typedef struct packed {
    logic [60:0]    rem;
    logic [30:0]    root;
    snei_pkg::pay_t pay;
  } sq_step_t;

  function automatic sq_step_t sq_step(input sq_step_t s, input int unsigned k);
    sq_step_t    n;
    logic [61:0] delta;
    n     = s;
    delta = (62'(s.root) << (k + 1)) + (62'(1) << (2 * k));
    if ({1'b0, s.rem} >= delta) begin
      n.rem  = 61'({1'b0, s.rem} - delta);
      n.root = s.root | (31'(1) << k);
    end
    return n;
  endfunction

  sq_step_t       st  [0:N];
  logic           vld [0:N];
  logic [31:0]    ratio;
  snei_pkg::pay_t pay0;

  always_comb begin
    ratio = in_pay.zero ? snei_pkg::ONE30 : quot_b;
    pay0  = in_pay;
    if (in_pay.blend && !in_pay.zero) begin
      if (in_pay.sep) pay0.ge = quot_a;
      else pay0.te = quot_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].rem  <= {ratio[30:0], 30'h0};
      st[0].root <= '0;
      st[0].pay  <= pay0;
    end
  end

  for (genvar j = 1; j <= N; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) vld[j] <= 1'b0;
      else if (en) vld[j] <= vld[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) st[j] <= sq_step(st[j-1], N - j);
    end
  end

  assign out_v   = vld[N];
  assign root    = st[N].root;
  assign out_pay = st[N].pay;

endmodule

// ----- rtl/core/snei_back.sv -----
// Back stages: velocity scaling, kinetic energy and the output register.
module snei_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  logic [30:0]    root,
  input  snei_pkg::pay_t in_pay,
  output logic           out_v,
  output snei_pkg::res_t res
);

  logic [31:0]    vin   [3];
  logic [31:0]    mag   [3];

  logic           b1_v;
  logic [62:0]    b1_prod [3];
  logic           b1_neg  [3];
  snei_pkg::pay_t b1_pay;

  logic           b2_v;
  logic [31:0]    b2_vel [3];
  snei_pkg::pay_t b2_pay;

  logic           b3_v;
  logic [31:0]    b3_vel [3];
  logic [63:0]    b3_sq  [3];
  snei_pkg::pay_t b3_pay;

  logic [31:0]    sc    [3];
  logic [31:0]    mag2  [3];
  logic [65:0]    ke;
  logic [65:0]    tsum;
  logic           apply;

  always_comb begin
    vin[0] = in_pay.vel_x;
    vin[1] = in_pay.vel_y;
    vin[2] = in_pay.vel_z;
    for (int i = 0; i < 3; i++) begin
      mag[i]  = vin[i][31] ? 32'(33'h0 - 33'(vin[i])) : vin[i];
      sc[i]   = b1_prod[i][61:30];
      mag2[i] = b2_vel[i][31] ? 32'(33'h0 - 33'(b2_vel[i])) : b2_vel[i];
    end
    ke    = 66'(b3_sq[0]) + 66'(b3_sq[1]) + 66'(b3_sq[2]);
    tsum  = 66'(b3_pay.ge) + (ke >> 17);
    apply = b3_pay.blend && b3_pay.sep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v  <= 1'b0;
      b2_v  <= 1'b0;
      b3_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      b1_v  <= in_v;
      b2_v  <= b1_v;
      b3_v  <= b2_v;
      out_v <= b3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b1_prod[i] <= 63'(mag[i]) * 63'(root);
        b1_neg[i]  <= vin[i][31];
        b2_vel[i]  <= b1_neg[i] ? 32'(33'h0 - 33'(sc[i])) : sc[i];
        b3_vel[i]  <= b2_vel[i];
        b3_sq[i]   <= 64'(mag2[i]) * 64'(mag2[i]);
      end
      b1_pay <= in_pay;
      b2_pay <= b1_pay;
      b3_pay <= b2_pay;

      res.inside_res          <= b3_pay.hit;
      res.new_density         <= b3_pay.dens;
      res.new_internal_energy <= b3_pay.ge;
      res.new_total_energy    <= apply ? ((|tsum[65:32]) ? '1 : tsum[31:0]) : b3_pay.te;
      res.new_vel_x           <= apply ? b3_vel[0] : b3_pay.vel_x;
      res.new_vel_y           <= apply ? b3_vel[1] : b3_pay.vel_y;
      res.new_vel_z           <= apply ? b3_vel[2] : b3_pay.vel_z;
      res.new_cr_energy       <= b3_pay.cr;
      res.new_colour          <= b3_pay.col;
    end
  end

endmodule

// ----- rtl/core/supernova_energy_injection_cell.sv -----
// Top level of the supernova energy injection cell.
// The block takes one grid cell per transaction on cell_in and returns one
// updated cell per transaction on cell_out, in order. Registers are written
// through cfg, which is always ready; write them only while no cell is in
// flight. Each cell passes through 72 register stages: three front stages,
// a 33-stage divider, a 32-stage square root and four back stages, the last
// of which is the output register. A new cell is accepted in every cycle
// unless the receiver stalls; the throughput is one cell per cycle without stalls.
// The whole pipeline advances together: when the output register holds
// a result that the receiver does not take, every stage holds and
// cell_in.ready falls, so nothing is lost or repeated. Reset clears the
// configuration registers to zero and empties the pipeline.
module supernova_energy_injection_cell #(
  parameter int COORD_BITS = 16
) (
  input logic           clk,
  input logic           rst,
  snei_stream_if.sink   cfg,
  snei_stream_if.sink   cell_in,
  snei_stream_if.source cell_out
);

  snei_pkg::regs_t regs;
  logic            en;
  logic            out_v;

  logic            f_v;
  logic [64:0]     f_num_a;
  logic [64:0]     f_num_b;
  logic [31:0]     f_den;
  snei_pkg::pay_t  f_pay;

  logic            d_v;
  logic [31:0]     d_quot_a;
  logic [31:0]     d_quot_b;
  snei_pkg::pay_t  d_pay;

  logic            q_v;
  logic [30:0]     q_root;
  snei_pkg::pay_t  q_pay;

  snei_pkg::res_t  res;

  assign cfg.ready      = 1'b1;
  assign en             = !out_v || cell_out.ready;
  assign cell_in.ready  = en;
  assign cell_out.valid = out_v;
  assign cell_out.data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.data.reg_index)
        snei_pkg::REG_SN_CENTER:   regs.sn_center   <= cfg.data.wr_data;
        snei_pkg::REG_RADIUS_SQ:   regs.radius_sq   <= cfg.data.wr_data[31:0];
        snei_pkg::REG_DENSITY_ADD: regs.density_add <= cfg.data.wr_data[31:0];
        snei_pkg::REG_THERMAL_ADD: regs.thermal_add <= cfg.data.wr_data[31:0];
        snei_pkg::REG_CR_ADD:      regs.cr_add      <= cfg.data.wr_data[31:0];
        snei_pkg::REG_COLOUR_ADD:  regs.colour_add  <= cfg.data.wr_data[31:0];
        snei_pkg::REG_MODE_FLAGS:  regs.mode        <= cfg.data.wr_data[3:0];
        default: ;
      endcase
    end
  end

  snei_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_v      (cell_in.valid),
    .cell_data (cell_in.data),
    .regs      (regs),
    .out_v     (f_v),
    .num_a     (f_num_a),
    .num_b     (f_num_b),
    .den       (f_den),
    .pay       (f_pay)
  );

  snei_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (f_v),
    .num_a   (f_num_a),
    .num_b   (f_num_b),
    .den     (f_den),
    .in_pay  (f_pay),
    .out_v   (d_v),
    .quot_a  (d_quot_a),
    .quot_b  (d_quot_b),
    .out_pay (d_pay)
  );

  snei_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (d_v),
    .quot_a  (d_quot_a),
    .quot_b  (d_quot_b),
    .in_pay  (d_pay),
    .out_v   (q_v),
    .root    (q_root),
    .out_pay (q_pay)
  );

  snei_back u_back (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (q_v),
    .root   (q_root),
    .in_pay (q_pay),
    .out_v  (out_v),
    .res    (res)
  );

endmodule

// ----- rtl/core/snei_check.sv -----
// Port-level checks of the supernova energy injection cell, bound to the top level.
module snei_check (
  input logic           clk,
  input logic           rst,
  input logic           cfg_ready,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input snei_pkg::res_t out_data
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("Input ready does not follow the output register.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("Configuration channel not ready.");

endmodule

bind supernova_energy_injection_cell snei_check u_snei_check (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg.ready),
  .in_ready  (cell_in.ready),
  .out_valid (cell_out.valid),
  .out_ready (cell_out.ready),
  .out_data  (cell_out.data)
);

// ----- tb/snei_checker.sv -----
// Checker that predicts each updated cell and compares it with the block's output.
`timescale 1ns / 100ps
module snei_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  snei_pkg::cfg_t  cfg_data,
  input  logic            in_valid,
  input  logic            in_ready,
  input  snei_pkg::cell_t in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  snei_pkg::res_t  out_data,
  output int              fail_count,
  output int              pending
);

  snei_pkg::regs_t regs;
  snei_pkg::res_t  expected_cells[$];

  assign pending = expected_cells.size();

  function automatic logic [63:0] axis_gap(logic [15:0] c, logic [15:0] p, bit wrap);
    logic [63:0] d;
    logic [63:0] alt;
    d = (c >= p) ? 64'(c - p) : 64'(p - c);
    if (wrap) begin
      alt = 64'h1_0000 - d;
      if (alt < d) d = alt;
    end
    return d;
  endfunction

  function automatic logic [31:0] clamp32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] weigh_energy(logic [63:0] oldd, logic [63:0] spec,
                                               logic [63:0] add, logic [63:0] newd);
    logic [63:0] p;
    logic [63:0] a;
    if (newd == 0) return spec[31:0];
    p = oldd * spec;
    a = add << 16;
    return clamp32(p / newd + a / newd + (p % newd + a % newd) / newd);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic snei_pkg::res_t inject_energy(snei_pkg::cell_t c);
    snei_pkg::res_t r;
    logic [63:0] dist2, dx, dy, dz, oldd, newd, ratio, s, mag, sc, ke;
    logic [31:0] v[3];
    dx = axis_gap(c.cell_x, regs.sn_center[15:0], 1);
    dy = axis_gap(c.cell_y, regs.sn_center[31:16], 1);
    dz = axis_gap(c.cell_z, regs.sn_center[47:32], 0);
    dist2 = dx * dx + dy * dy + dz * dz;
    r.inside_res = 0;
    r.new_density = c.density;
    r.new_internal_energy = c.internal_energy;
    r.new_total_energy = c.total_energy;
    v[0] = c.vel_x;
    v[1] = c.vel_y;
    v[2] = c.vel_z;
    r.new_cr_energy = c.cr_energy;
    r.new_colour = c.colour;
    if (dist2 <= 64'(regs.radius_sq)) begin
      r.inside_res = 1;
      oldd = 64'(c.density);
      newd = 64'(clamp32(oldd + 64'(regs.density_add)));
      if (regs.mode[snei_pkg::MODE_CR]) r.new_cr_energy = regs.cr_add;
      if (regs.mode[snei_pkg::MODE_THERMAL]) begin
        if (regs.mode[snei_pkg::MODE_SEP]) begin
          r.new_internal_energy = weigh_energy(oldd, 64'(c.internal_energy),
                                               64'(regs.thermal_add), newd);
          ratio = (newd == 0) ? 64'(snei_pkg::ONE30) : (oldd << 30) / newd;
          s = root64(ratio << 30);
          ke = 0;
          for (int i = 0; i < 3; i++) begin
            mag = v[i][31] ? 64'(32'(-v[i])) : 64'(v[i]);
            if (v[i] == 32'h8000_0000) mag = 64'h8000_0000;
            sc = (mag * s) >> 30;
            v[i] = v[i][31] ? -sc[31:0] : sc[31:0];
            mag = v[i][31] ? 64'(32'(-v[i])) : 64'(v[i]);
            ke += mag * mag;
          end
          r.new_total_energy = clamp32(64'(r.new_internal_energy) + (ke >> 17));
        end else begin
          r.new_total_energy = weigh_energy(oldd, 64'(c.total_energy),
                                            64'(regs.thermal_add), newd);
        end
      end
      if (regs.mode[snei_pkg::MODE_COLOUR])
        r.new_colour = clamp32(64'(c.colour) + 64'(regs.colour_add));
      r.new_density = newd[31:0];
    end
    r.new_vel_x = v[0];
    r.new_vel_y = v[1];
    r.new_vel_z = v[2];
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    snei_pkg::res_t e;
    if (rst) begin
      regs <= '0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (snei_pkg::cfg_reg_t'(cfg_data.reg_index))
          snei_pkg::REG_SN_CENTER:   regs.sn_center <= cfg_data.wr_data;
          snei_pkg::REG_RADIUS_SQ:   regs.radius_sq <= cfg_data.wr_data[31:0];
          snei_pkg::REG_DENSITY_ADD: regs.density_add <= cfg_data.wr_data[31:0];
          snei_pkg::REG_THERMAL_ADD: regs.thermal_add <= cfg_data.wr_data[31:0];
          snei_pkg::REG_CR_ADD:      regs.cr_add <= cfg_data.wr_data[31:0];
          snei_pkg::REG_COLOUR_ADD:  regs.colour_add <= cfg_data.wr_data[31:0];
          snei_pkg::REG_MODE_FLAGS:  regs.mode <= cfg_data.wr_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_cells.push_back(inject_energy(in_data));
      if (out_valid && out_ready) begin
        if (expected_cells.size() == 0) begin
          $error("Unexpected result transaction");
          fail_count++;
        end else begin
          e = expected_cells.pop_front();
          compare_field("inside_res", 32'(e.inside_res), 32'(out_data.inside_res));
          compare_field("new_density", e.new_density, out_data.new_density);
          compare_field("new_internal_energy", e.new_internal_energy,
                        out_data.new_internal_energy);
          compare_field("new_total_energy", e.new_total_energy, out_data.new_total_energy);
          compare_field("new_vel_x", e.new_vel_x, out_data.new_vel_x);
          compare_field("new_vel_y", e.new_vel_y, out_data.new_vel_y);
          compare_field("new_vel_z", e.new_vel_z, out_data.new_vel_z);
          compare_field("new_cr_energy", e.new_cr_energy, out_data.new_cr_energy);
          compare_field("new_colour", e.new_colour, out_data.new_colour);
        end
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top that drives configuration and cells and reports the verdict.
`timescale 1ns / 100ps
module tb;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  bit   sink_idle_on;
  bit   long_hold;

  snei_stream_if #(snei_pkg::cfg_t)  cfg ();
  snei_stream_if #(snei_pkg::cell_t) cell_in ();
  snei_stream_if #(snei_pkg::res_t)  cell_out ();

  supernova_energy_injection_cell u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg.sink),
    .cell_in  (cell_in.sink),
    .cell_out (cell_out.source)
  );

  snei_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_data   (cfg.data),
    .in_valid   (cell_in.valid),
    .in_ready   (cell_in.ready),
    .in_data    (cell_in.data),
    .out_valid  (cell_out.valid),
    .out_ready  (cell_out.ready),
    .out_data   (cell_out.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int gap;
    cell_out.ready = 0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        cell_out.ready <= 0;
        repeat (300) @(negedge clk);
        long_hold = 0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 17);
        cell_out.ready <= 0;
        repeat (gap) @(negedge clk);
      end else begin
        cell_out.ready <= 1;
        @(negedge clk);
      end
    end
  end

  task automatic write_reg(snei_pkg::cfg_reg_t idx, logic [47:0] value);
    cfg.data <= '{reg_index: idx, wr_data: value};
    cfg.valid <= 1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task automatic send_cell(snei_pkg::cell_t c, bit idle_on);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      cell_in.valid <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    cell_in.data <= c;
    cell_in.valid <= 1;
    @(posedge clk);
    while (!cell_in.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    cell_in.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic snei_pkg::cell_t near_cell(logic [47:0] centre, int spread);
    snei_pkg::cell_t c;
    c.cell_x = centre[15:0] + 16'($urandom_range(0, 2 * spread) - spread);
    c.cell_y = centre[31:16] + 16'($urandom_range(0, 2 * spread) - spread);
    c.cell_z = centre[47:32] + 16'($urandom_range(0, 2 * spread) - spread);
    if ($urandom_range(0, 4) == 0) begin
      c.cell_x = 16'($urandom);
      c.cell_y = 16'($urandom);
      c.cell_z = 16'($urandom);
    end
    c.density = rand_word();
    c.internal_energy = rand_word();
    c.total_energy = rand_word();
    c.vel_x = rand_word();
    c.vel_y = rand_word();
    c.vel_z = rand_word();
    c.cr_energy = rand_word();
    c.colour = rand_word();
    return c;
  endfunction

  initial begin
    snei_pkg::cell_t c;
    logic [47:0] centre;
    int spread;
    cfg.valid = 0;
    cfg.data = '0;
    cell_in.valid = 0;
    cell_in.data = '0;
    sink_idle_on = 0;
    long_hold = 0;
    rst = 1;
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed cells over all 16 mode settings: centre hits, wrap edges and extremes.
    for (int m = 0; m < 16; m++) begin
      write_reg(snei_pkg::REG_MODE_FLAGS, 48'(m));
      write_reg(snei_pkg::REG_SN_CENTER, m[0] ? 48'hFFFF_FFFF_FFFF : 48'h0);
      write_reg(snei_pkg::REG_RADIUS_SQ, m[1] ? 48'hFFFF_FFFF : 48'd4);
      write_reg(snei_pkg::REG_DENSITY_ADD, m[2] ? 48'hFFFF_FFFF : 48'h0);
      write_reg(snei_pkg::REG_THERMAL_ADD, m[3] ? 48'hFFFF_FFFF : 48'h0001_0000);
      write_reg(snei_pkg::REG_CR_ADD, m[0] ? 48'hFFFF_FFFF : 48'h0);
      write_reg(snei_pkg::REG_COLOUR_ADD, m[1] ? 48'hFFFF_FFFF : 48'h0);
      c = '0;
      c.cell_x = 16'hFFFF;
      c.cell_y = 16'h0001;
      c.cell_z = m[0] ? 16'h0000 : 16'hFFFF;
      send_cell(c, 0);
      c.density = 32'hFFFF_FFFF;
      c.internal_energy = 32'hFFFF_FFFF;
      c.total_energy = 32'hFFFF_FFFF;
      c.vel_x = 32'h8000_0000;
      c.vel_y = 32'h7FFF_FFFF;
      c.vel_z = 32'hFFFF_FFFF;
      c.cr_energy = 32'hFFFF_FFFF;
      c.colour = 32'hFFFF_FFFF;
      c.cell_x = 16'($urandom);
      send_cell(c, 0);
      drain();
    end

    sink_idle_on = 1;
    for (int phase = 0; phase < 12; phase++) begin
      centre = 48'({$urandom, $urandom});
      spread = (phase % 3 == 0) ? 300 : 40;
      write_reg(snei_pkg::REG_SN_CENTER, centre);
      write_reg(snei_pkg::REG_RADIUS_SQ,
                (phase == 5) ? 48'hFFFF_FFFF : 48'($urandom_range(0, 40000)));
      write_reg(snei_pkg::REG_DENSITY_ADD, 48'(rand_word()));
      write_reg(snei_pkg::REG_THERMAL_ADD, 48'(rand_word()));
      write_reg(snei_pkg::REG_CR_ADD, 48'(rand_word()));
      write_reg(snei_pkg::REG_COLOUR_ADD, 48'(rand_word()));
      write_reg(snei_pkg::REG_MODE_FLAGS, (phase < 2) ? 48'hF : 48'($urandom_range(0, 15)));
      if (phase == 3) long_hold = 1;
      if (phase == 10) sink_idle_on = 0;
      for (int i = 0; i < 150; i++) send_cell(near_cell(centre, spread), phase < 10);
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
